// File: rtl/mbp_pkg.sv
`default_nettype none
// ============================================================================
// mbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ============================================================================
package mbp_pkg;

    // Default accumulator width in bits (a multiple of 8, 16 to 64).
    localparam int MBP_WORD_BITS = 32;

    // Depth of the job queue between the front and the back.
    localparam int MBP_QUEUE_DEPTH = 2;
    localparam int MBP_QPTR_W      = $clog2(MBP_QUEUE_DEPTH);

    // Command codes. The reserved code is accepted and ignored.
    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_FLUSH    = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    // Input item.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] data_bits;
        logic [5:0]  field_len;
    } t_mbp_in;

    // Result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_mbp_out;

endpackage : mbp_pkg
`default_nettype wire

// File: rtl/mbp_front.sv
`default_nettype none
// ============================================================================
// mbp_front
// Accepts commands, updates the accumulator and issues byte jobs.
// ============================================================================
module mbp_front import mbp_pkg::*; #(
    parameter int WORD_BITS = MBP_WORD_BITS,
    localparam int NBW = $clog2(WORD_BITS / 8 + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_mbp_in              i_in,
    output logic                      o_job_valid,
    input  wire logic                 i_job_ready,
    output logic [WORD_BITS-1:0]      o_job_word,
    output logic [NBW-1:0]            o_job_nbytes
);

    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int SW = $clog2(2 * WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [CW-1:0]        r_pend, n_pend;

    logic                 accept;
    logic [SW-1:0]        count_ext, count_c, sum, room, rest, flush_nb;
    logic [WORD_BITS-1:0] bits_w, bits_m;

    assign o_in_stall = !i_job_ready;
    assign accept     = i_in_valid && i_job_ready;

    always_comb begin
        count_ext = SW'(i_in.field_len);
        count_c   = (count_ext > SW'(WORD_BITS)) ? SW'(WORD_BITS) : count_ext;
        bits_w    = WORD_BITS'(i_in.data_bits);
        bits_m    = bits_w & ~({WORD_BITS{1'b1}} << count_c);
        sum       = SW'(r_pend) + count_c;
        room      = SW'(WORD_BITS) - SW'(r_pend);
        rest      = count_c - room;
        flush_nb  = (SW'(r_pend) + SW'(7)) >> 3;

        n_acc        = r_acc;
        n_pend       = r_pend;
        o_job_valid  = 1'b0;
        o_job_word   = '0;
        o_job_nbytes = '0;

        unique case (i_in.command)
            CMD_WRITE: begin
                if (sum <= SW'(WORD_BITS)) begin
                    n_acc  = (r_acc << count_c) | bits_m;
                    n_pend = CW'(sum);
                end else begin
                    o_job_valid  = i_in_valid;
                    o_job_word   = (r_acc << room) | (bits_m >> rest);
                    o_job_nbytes = NBW'(WORD_BITS / 8);
                    n_acc        = bits_m & ~({WORD_BITS{1'b1}} << rest);
                    n_pend       = CW'(rest);
                end
            end
            CMD_FLUSH: begin
                o_job_valid  = i_in_valid && (r_pend != '0);
                o_job_word   = r_acc << (SW'(WORD_BITS) - SW'(r_pend));
                o_job_nbytes = NBW'(flush_nb);
                n_acc        = '0;
                n_pend       = '0;
            end
            CMD_CLEAR: begin
                n_acc  = '0;
                n_pend = '0;
            end
            default: begin
                n_acc  = r_acc;
                n_pend = r_pend;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
        end else if (accept) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule : mbp_front
`default_nettype wire

// File: rtl/mbp_queue.sv
`default_nettype none
// ============================================================================
// mbp_queue
// Short job queue that decouples the front from the byte sequencer.
// ============================================================================
module mbp_queue import mbp_pkg::*; #(
    parameter int WORD_BITS = MBP_WORD_BITS,
    localparam int NBW = $clog2(WORD_BITS / 8 + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push_valid,
    output logic                      o_push_ready,
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [NBW-1:0]       i_nbytes,
    output logic                      o_pop_valid,
    input  wire logic                 i_pop,
    output logic [WORD_BITS-1:0]      o_word,
    output logic [NBW-1:0]            o_nbytes
);

    localparam int CNTW = $clog2(MBP_QUEUE_DEPTH + 1);

    logic [WORD_BITS-1:0] r_word [MBP_QUEUE_DEPTH];
    logic [NBW-1:0]       r_nb   [MBP_QUEUE_DEPTH];
    logic [MBP_QPTR_W-1:0] r_wp, r_rp;
    logic [CNTW-1:0]      r_cnt;
    logic                 do_push, do_pop;

    assign o_push_ready = (r_cnt != CNTW'(MBP_QUEUE_DEPTH));
    assign do_push      = i_push_valid && o_push_ready;
    assign o_pop_valid  = (r_cnt != '0);
    assign do_pop       = o_pop_valid && i_pop;
    assign o_word       = r_word[r_rp];
    assign o_nbytes     = r_nb[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_word[r_wp] <= i_word;
            r_nb[r_wp]   <= i_nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == MBP_QPTR_W'(MBP_QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == MBP_QPTR_W'(MBP_QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule : mbp_queue
`default_nettype wire

// File: rtl/mbp_back.sv
`default_nettype none
// ============================================================================
// mbp_back
// Byte sequencer: takes jobs and sends their bytes, high byte first.
// ============================================================================
module mbp_back import mbp_pkg::*; #(
    parameter int WORD_BITS = MBP_WORD_BITS,
    localparam int NBW = $clog2(WORD_BITS / 8 + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_job_valid,
    output logic                      o_job_pop,
    input  wire logic [WORD_BITS-1:0] i_job_word,
    input  wire logic [NBW-1:0]       i_job_nbytes,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_mbp_out                  o_out
);

    logic [WORD_BITS-1:0] r_word;
    logic [NBW-1:0]       r_left;
    logic                 r_out_valid;
    t_mbp_out             r_out;
    logic                 adv;

    assign adv       = !r_out_valid || !i_out_stall;
    // Load the next job when idle or as the last byte of this one leaves.
    assign o_job_pop = i_job_valid &&
                       ((r_left == '0) || ((r_left == NBW'(1)) && adv));

    always_ff @(posedge i_clk) begin
        if (adv && (r_left != '0)) begin
            r_out.out_byte <= r_word[WORD_BITS-1 -: 8];
            r_out.last     <= (r_left == NBW'(1));
        end
        if (o_job_pop) begin
            r_word <= i_job_word;
        end else if (adv && (r_left != '0)) begin
            r_word <= r_word << 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= (r_left != '0);
            end
            if (o_job_pop) begin
                r_left <= i_job_nbytes;
            end else if (adv && (r_left != '0)) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule : mbp_back
`default_nettype wire

// File: rtl/msb_first_bit_packer_core.sv
`default_nettype none
// ============================================================================
// msb_first_bit_packer_core
// Packs variable-length fields MSB first and sends the words out as bytes.
// ============================================================================
//
//  Channel  Direction  Signals                       Transfer when
//  -------  ---------  ----------------------------  --------------------------
//  input    in         i_in_valid, o_in_stall, i_in  i_in_valid && !o_in_stall
//  output   out        o_out_valid, i_out_stall,     o_out_valid && !i_out_stall
//                      o_out
//
//  The front takes one command per cycle while the queue has room and updates the
//  accumulator in that cycle; an overflowing write, or a flush with bits pending,
//  pushes a word into a two-entry job queue. The sequencer loads the job once it
//  is free, then sends one byte per cycle unless stalled (WORD_BITS/8 for a word).
//  Synchronous active-low reset empties the accumulator, queue and output register.
//  o_in_stall rises only when the queue is full; an output stall holds the byte.
//
module msb_first_bit_packer_core import mbp_pkg::*; #(
    parameter int WORD_BITS = MBP_WORD_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_mbp_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_mbp_out      o_out
);

    localparam int NBW = $clog2(WORD_BITS / 8 + 1);

    // Job from the front into the queue.
    logic                 front_job_valid;
    logic                 queue_push_ready;
    logic [WORD_BITS-1:0] front_job_word;
    logic [NBW-1:0]       front_job_nbytes;

    // Head of the queue towards the byte sequencer.
    logic                 head_valid;
    logic                 back_pop;
    logic [WORD_BITS-1:0] head_word;
    logic [NBW-1:0]       head_nbytes;

    // The front classifies each command and keeps the pending bits.
    mbp_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .o_job_valid  (front_job_valid),
        .i_job_ready  (queue_push_ready),
        .o_job_word   (front_job_word),
        .o_job_nbytes (front_job_nbytes)
    );

    // Jobs wait here while the sequencer is busy with an earlier burst.
    mbp_queue #(
        .WORD_BITS (WORD_BITS)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_job_valid),
        .o_push_ready (queue_push_ready),
        .i_word       (front_job_word),
        .i_nbytes     (front_job_nbytes),
        .o_pop_valid  (head_valid),
        .i_pop        (back_pop),
        .o_word       (head_word),
        .o_nbytes     (head_nbytes)
    );

    // The back turns each job into a burst of bytes with last on the final one.
    mbp_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (head_valid),
        .o_job_pop    (back_pop),
        .i_job_word   (head_word),
        .i_job_nbytes (head_nbytes),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule : msb_first_bit_packer_core
`default_nettype wire

// File: test/tb_msb_first_bit_packer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_msb_first_bit_packer_core
// Self-checking testbench for the MSB-first bit packer.
// ============================================================================
//
// A behavioral model of the packer runs next to the block. A monitor sees
// every accepted command and works out the bytes it must cause. It also
// compares every accepted output byte, field by field, with the oldest
// pending prediction. The stimulus begins with a short directed part that
// covers the corner cases. It goes on with random write streams closed by a
// flush or a clear, then random noise with every command code, and ends
// with a stretch at full rate. Both sides insert random idle bursts, except
// in the final stretch.
//
module tb_msb_first_bit_packer_core;
    import mbp_pkg::*;

    localparam int          WB          = MBP_WORD_BITS;
    localparam logic [63:0] WORD_MASK   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WB);
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 20;
    localparam int          MAX_PRINTS  = 40;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_mbp_in  i_in        = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_mbp_out o_out;

    // Model state: pending bits, right aligned, and how many there are.
    logic [63:0] pend_bits  = '0;
    int unsigned pend_count = 0;

    t_mbp_out expected_bytes[$];

    int  error_count   = 0;
    int  items_sent    = 0;
    int  bytes_checked = 0;
    bit  in_idle_on    = 1'b0;
    bit  out_idle_on   = 1'b0;
    int  out_hold      = 0;

    msb_first_bit_packer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Queues the top nbytes bytes of a left-aligned word, high byte first.
    // The final byte of the group carries the last flag.
    function automatic void queue_word_bytes(input logic [63:0] word, input int nbytes);
        t_mbp_out one_byte;
        for (int i = 0; i < nbytes; i++) begin
            one_byte.out_byte = 8'((word >> (WB - 8 - 8 * i)) & 64'hFF);
            one_byte.last     = (i == nbytes - 1);
            expected_bytes.push_back(one_byte);
        end
    endfunction

    // Updates the model with one accepted command and queues the bytes it
    // must produce.
    function automatic void predict_packed_bytes(input t_mbp_in item);
        int unsigned count;
        int unsigned room;
        int unsigned rest;
        logic [63:0] field;
        logic [63:0] word;
        count = (item.field_len > WB) ? WB : item.field_len;
        field = {32'b0, item.data_bits} & ((64'd1 << count) - 64'd1);
        case (item.command)
            CMD_WRITE: begin
                if (pend_count + count <= WB) begin
                    // The field fits, even if it fills the word exactly.
                    pend_bits  = ((pend_bits << count) | field) & WORD_MASK;
                    pend_count = pend_count + count;
                end else begin
                    // Complete the word with the head of the field, send it,
                    // and keep the tail of the field pending.
                    room = WB - pend_count;
                    rest = count - room;
                    word = ((pend_bits << room) | (field >> rest)) & WORD_MASK;
                    queue_word_bytes(word, WB / 8);
                    pend_bits  = field & ((64'd1 << rest) - 64'd1);
                    pend_count = rest;
                end
            end
            CMD_FLUSH: begin
                if (pend_count != 0) begin
                    word = (pend_bits << (WB - pend_count)) & WORD_MASK;
                    queue_word_bytes(word, (pend_count + 7) / 8);
                end
                pend_bits  = '0;
                pend_count = 0;
            end
            CMD_CLEAR: begin
                pend_bits  = '0;
                pend_count = 0;
            end
            default: begin
                // The unused code leaves everything as it is.
            end
        endcase
    endfunction

    // The monitor samples on the rising edge, so it sees the values that
    // were present during the cycle that just ended. Prediction runs before
    // the byte check so that ordering inside a step never matters.
    always @(posedge i_clk) begin
        t_mbp_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) begin
                predict_packed_bytes(i_in);
            end
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              o_out.out_byte, o_out.last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                                  o_out.out_byte, want.out_byte));
                    end
                    if (o_out.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, predicted %0b (byte %02h)",
                                                  o_out.last, want.last, want.out_byte));
                    end
                end
            end
        end
    end

    // The output stall comes in random bursts while enabled and
    // drops at once when idling is switched off.
    always @(posedge i_clk) begin
        if (!out_idle_on) begin
            i_out_stall <= 1'b0;
            out_hold    <= 0;
        end else if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= out_hold - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= $urandom_range(1, 9) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_mbp_in make_item(input logic [1:0] cmd, input logic [31:0] data,
                                          input logic [5:0] count);
        t_mbp_in item;
        item.command   = cmd;
        item.data_bits = data;
        item.field_len = count;
        return item;
    endfunction

    // Mostly in-range counts, with the edges and oversized values mixed in.
    function automatic logic [5:0] random_count();
        case ($urandom_range(0, 9))
            0:       return 6'($urandom_range(33, 63));
            1:       return 6'd32;
            2:       return 6'd0;
            default: return 6'($urandom_range(1, 31));
        endcase
    endfunction

    function automatic logic [31:0] random_data();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Presents one command and returns at the edge where it is transferred.
    // An idle gap, when one is drawn, comes before the command goes out.
    task automatic send_item(input t_mbp_in item);
        int gap;
        gap = 0;
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic test_special_cases();
        in_idle_on  = 1'b1;
        out_idle_on <= 1'b1;
        // A flush right after reset has nothing to send.
        send_item(make_item(CMD_FLUSH, 32'hFFFF_FFFF, 6'd63));
        // A zero-length write changes nothing.
        send_item(make_item(CMD_WRITE, 32'hFFFF_FFFF, 6'd0));
        // A full word stays put until one more bit arrives.
        send_item(make_item(CMD_WRITE, 32'hFFFF_FFFF, 6'd32));
        send_item(make_item(CMD_WRITE, 32'h0000_0001, 6'd1));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        // Oversized counts act as a full word.
        send_item(make_item(CMD_WRITE, 32'hA5A5_A5A5, 6'd63));
        send_item(make_item(CMD_WRITE, 32'h5A5A_5A5A, 6'd33));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        // Flushes of one, two, three and four partial bytes.
        send_item(make_item(CMD_WRITE, 32'hFFFF_FF7F, 6'd7));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(CMD_WRITE, 32'h0000_0155, 6'd9));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(CMD_WRITE, 32'hFFC3_C3C3, 6'd24));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(CMD_WRITE, 32'h8000_0001, 6'd31));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        // An overflow followed by a clear: the leftover bits are dropped.
        send_item(make_item(CMD_WRITE, 32'h0000_0000, 6'd31));
        send_item(make_item(CMD_WRITE, 32'h0000_001F, 6'd5));
        send_item(make_item(CMD_CLEAR, 32'hFFFF_FFFF, 6'd32));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        // The unused command code must not touch the pending bits.
        send_item(make_item(CMD_WRITE, 32'h0000_0ABC, 6'd12));
        send_item(make_item(CMD_RESERVED, 32'hFFFF_FFFF, 6'd32));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
    endtask

    // Well-formed streams: a run of writes closed by a flush, or now and
    // then by a clear. Idling is switched per stream.
    task automatic test_write_flush_streams(input int n_items);
        int sent;
        int writes;
        sent = 0;
        while (sent < n_items) begin
            in_idle_on  = ($urandom_range(0, 2) != 0);
            out_idle_on <= ($urandom_range(0, 2) != 0);
            writes = $urandom_range(1, 8);
            for (int i = 0; i < writes; i++) begin
                send_item(make_item(CMD_WRITE, random_data(), random_count()));
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(make_item(CMD_CLEAR, random_data(), random_count()));
            end else begin
                send_item(make_item(CMD_FLUSH, random_data(), random_count()));
            end
            sent = sent + writes + 1;
        end
    endtask

    // Random commands, unused code included, with random payload bits.
    task automatic test_mixed_commands(input int n_items);
        logic [1:0] cmd;
        in_idle_on  = 1'b1;
        out_idle_on <= 1'b1;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 9))
                0:       cmd = CMD_CLEAR;
                1:       cmd = CMD_RESERVED;
                2, 3:    cmd = CMD_FLUSH;
                default: cmd = CMD_WRITE;
            endcase
            send_item(make_item(cmd, $urandom, 6'($urandom_range(0, 63))));
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate(input int n_items);
        in_idle_on  = 1'b0;
        out_idle_on <= 1'b0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 5 == 4) begin
                send_item(make_item(CMD_FLUSH, $urandom, 6'd0));
            end else begin
                send_item(make_item(CMD_WRITE, random_data(), random_count()));
            end
        end
    endtask

    initial begin
        int waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_write_flush_streams(110);
        test_mixed_commands(60);
        test_full_rate(40);

        // Stop sending, let every predicted byte come out, then keep watching
        // the output for anything extra.
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d predicted bytes never came out",
                                      expected_bytes.size()));
        end

        $display("Covered %0d commands (writes, flushes, clears, unused code) and %0d bytes",
                 items_sent, bytes_checked);
        $display("with random idle bursts on both sides; %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #400_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: msb_first_bit_packer_core.f
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_first_bit_packer_core.sv
test/tb_msb_first_bit_packer_core.sv
